[rtl/tts_pkg.sv]
package tts_pkg;

  localparam int DEF_SLOTS      = 16;
  localparam int DEF_TICK_WIDTH = 16;

  localparam logic [2:0] REQ_TICK     = 3'd0;
  localparam logic [2:0] REQ_ADD      = 3'd1;
  localparam logic [2:0] REQ_DELETE   = 3'd2;
  localparam logic [2:0] REQ_DISPATCH = 3'd3;
  localparam logic [2:0] REQ_CLEAR    = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic [4:0] NONE_SLOT = 5'd16;
  localparam logic [7:0] PEND_MAX  = 8'd255;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_ADD,
    OP_DELETE,
    OP_DISPATCH,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  ident;
    logic [15:0] delay;
    logic [15:0] period;
    logic [3:0]  target;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] slot_index;
    logic [7:0] due_ident;
    logic       task_due;
    logic       sticky_error;
    logic       last;
  } rsp_t;

endpackage

[rtl/tts_if.sv]
interface tts_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  task_ident;
  logic [15:0] first_delay;
  logic [15:0] repeat_period;
  logic [3:0]  target_slot;

  modport source (
    output valid, req_type, task_ident, first_delay, repeat_period, target_slot,
    input  ready
  );
  modport sink (
    input  valid, req_type, task_ident, first_delay, repeat_period, target_slot,
    output ready
  );
endinterface

interface tts_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] slot_index;
  logic [7:0] due_ident;
  logic       task_due;
  logic       sticky_error;
  logic       last;

  modport source (
    output valid, status, slot_index, due_ident, task_due, sticky_error, last,
    input  ready
  );
  modport sink (
    input  valid, status, slot_index, due_ident, task_due, sticky_error, last,
    output ready
  );
endinterface

[rtl/tts_front.sv]
module tts_front import tts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tts_req_if.sink    req_i,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i,
  output cmd_t       cmd_o
);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  cmd_t       cmd_in;

  // request decode
  always_comb begin
    cmd_in.ident  = req_i.task_ident;
    cmd_in.delay  = req_i.first_delay;
    cmd_in.period = req_i.repeat_period;
    cmd_in.target = req_i.target_slot;
    unique case (req_i.req_type)
      REQ_TICK:     cmd_in.op = OP_TICK;
      REQ_ADD:      cmd_in.op = OP_ADD;
      REQ_DELETE:   cmd_in.op = OP_DELETE;
      REQ_DISPATCH: cmd_in.op = OP_DISPATCH;
      REQ_CLEAR:    cmd_in.op = OP_CLEAR;
      default:      cmd_in.op = OP_NOP;
    endcase
  end

  assign req_i.ready = (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[rtl/tts_back.sv]
module tts_back import tts_pkg::*; #(
  parameter int SLOTS      = DEF_SLOTS,
  parameter int TICK_WIDTH = DEF_TICK_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  input  cmd_t       cmd_i,
  tts_rsp_if.source  rsp_o
);

  localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CntW  = $clog2(SLOTS + 1);

  typedef struct packed {
    logic [7:0]            ident;
    logic [TICK_WIDTH-1:0] delay;
    logic [TICK_WIDTH-1:0] period;
    logic [7:0]            pending;
  } entry_t;

  back_state_e      state_q, state_d;
  op_e              op_q;
  entry_t           mem_q [SLOTS];
  entry_t           rd_data_q;
  logic [SLOTS-1:0] valid_q, valid_d;
  logic [SLOTS-1:0] pnz_q, pnz_d;
  logic             err_q, err_d;
  logic [CntW-1:0]  rd_cnt_q;
  logic             p_vld_q;
  logic [SlotW-1:0] p_idx_q;
  logic             out_vld_q;
  rsp_t             out_q;

  logic             out_free, cmd_scan, pop, any_free, tgt_in;
  logic [SlotW-1:0] free_idx, tgt_idx, mem_waddr;
  logic [SLOTS-1:0] later;
  entry_t           ent, ent_new, mem_wdata;
  logic             p_v, emit, stall, adv, issue, mem_we, out_load, scan_end;
  rsp_t             res;

  assign out_free = !out_vld_q || rsp_o.ready;
  assign cmd_scan = (cmd_i.op == OP_TICK) || ((cmd_i.op == OP_DISPATCH) && (|pnz_q));
  assign pop      = cmd_valid_i && cmd_ready_o;
  assign any_free = ~&valid_q;
  assign tgt_in   = int'(cmd_i.target) < SLOTS;
  assign tgt_idx  = SlotW'(cmd_i.target);

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = SlotW'(i);
      end
    end
  end

  // slots above the one in the process stage
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      later[i] = (i > int'(p_idx_q));
    end
  end

  // process stage: one slot per cycle unless a dispatch word is stalled
  always_comb begin
    p_v     = valid_q[p_idx_q];
    ent     = p_v ? rd_data_q : '0;
    ent_new = ent;
    if (op_q == OP_TICK) begin
      if (p_v) begin
        if (ent.delay == '0) begin
          if (ent.pending != PEND_MAX) begin
            ent_new.pending = ent.pending + 8'd1;
          end
          if (ent.period != '0) begin
            ent_new.delay = ent.period;
          end
        end else begin
          ent_new.delay = ent.delay - TICK_WIDTH'(1);
        end
      end
    end else begin
      if (pnz_q[p_idx_q]) begin
        ent_new.pending = ent.pending - 8'd1;
      end
    end
  end

  assign emit     = p_vld_q && (op_q == OP_DISPATCH) && pnz_q[p_idx_q];
  assign stall    = emit && !out_free;
  assign adv      = p_vld_q && !stall;
  assign issue    = (state_q == ST_SCAN) && (int'(rd_cnt_q) < SLOTS) && !stall;
  assign scan_end = (int'(rd_cnt_q) == SLOTS) && !(p_vld_q && stall);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop && cmd_scan) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = (op_q == OP_TICK) ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and table updates
  always_comb begin
    cmd_ready_o      = 1'b0;
    valid_d          = valid_q;
    pnz_d            = pnz_q;
    err_d            = err_q;
    mem_we           = 1'b0;
    mem_waddr        = p_idx_q;
    mem_wdata        = ent_new;
    out_load         = 1'b0;
    res.status       = STATUS_OK;
    res.slot_index   = NONE_SLOT;
    res.due_ident    = 8'd0;
    res.task_due     = 1'b0;
    res.sticky_error = err_q;
    res.last         = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = cmd_scan || out_free;
        if (pop && !cmd_scan) begin
          out_load = 1'b1;
          case (cmd_i.op)
            OP_ADD: begin
              if (any_free) begin
                mem_we            = 1'b1;
                mem_waddr         = free_idx;
                mem_wdata.ident   = cmd_i.ident;
                mem_wdata.delay   = TICK_WIDTH'(cmd_i.delay);
                mem_wdata.period  = TICK_WIDTH'(cmd_i.period);
                mem_wdata.pending = 8'd0;
                valid_d[free_idx] = 1'b1;
                pnz_d[free_idx]   = 1'b0;
                res.slot_index    = 5'(free_idx);
              end else begin
                err_d      = 1'b1;
                res.status = STATUS_FULL;
              end
            end
            OP_DELETE: begin
              if (tgt_in) begin
                if (!valid_q[tgt_idx]) begin
                  err_d      = 1'b1;
                  res.status = STATUS_EMPTY;
                end
                valid_d[tgt_idx] = 1'b0;
                pnz_d[tgt_idx]   = 1'b0;
              end else begin
                err_d      = 1'b1;
                res.status = STATUS_EMPTY;
              end
            end
            OP_CLEAR: begin
              valid_d = '0;
              pnz_d   = '0;
              err_d   = 1'b0;
            end
            default: ;
          endcase
          res.sticky_error = err_d;
        end
      end
      ST_SCAN: begin
        if (adv) begin
          mem_we = 1'b1;
          if (op_q == OP_TICK) begin
            pnz_d[p_idx_q] = ent_new.pending != 8'd0;
          end else if (pnz_q[p_idx_q]) begin
            if (ent.period == '0) begin
              valid_d[p_idx_q] = 1'b0;
              pnz_d[p_idx_q]   = 1'b0;
            end else begin
              pnz_d[p_idx_q] = ent_new.pending != 8'd0;
            end
          end
        end
        if (emit && out_free) begin
          out_load       = 1'b1;
          res.slot_index = 5'(p_idx_q);
          res.due_ident  = ent.ident;
          res.task_due   = 1'b1;
          res.last       = ~|(pnz_q & later);
        end
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_data_q <= mem_q[rd_cnt_q[SlotW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      op_q <= cmd_i.op;
    end
    if (issue) begin
      p_idx_q <= rd_cnt_q[SlotW-1:0];
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      pnz_q     <= '0;
      err_q     <= 1'b0;
      rd_cnt_q  <= '0;
      p_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      pnz_q   <= pnz_d;
      err_q   <= err_d;
      if (pop) begin
        rd_cnt_q <= '0;
      end else if (issue) begin
        rd_cnt_q <= rd_cnt_q + CntW'(1);
      end
      if (issue) begin
        p_vld_q <= 1'b1;
      end else if (adv) begin
        p_vld_q <= 1'b0;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.slot_index   = out_q.slot_index;
  assign rsp_o.due_ident    = out_q.due_ident;
  assign rsp_o.task_due     = out_q.task_due;
  assign rsp_o.sticky_error = out_q.sticky_error;
  assign rsp_o.last         = out_q.last;

endmodule

[rtl/tick_task_scheduler_table.sv]
// Tick-driven task table with SLOTS slots. Requests enter a two-word queue and
// are executed one at a time against a slot memory with one read and one write
// port. Add, delete, clear, unused codes and a dispatch with nothing pending are
// handled in the back end without a scan; a tick walks the memory one slot per
// cycle, and a dispatch with pending runs does the same except while the response
// side stalls one of its words.
// Dispatch returns one word per ready slot, lowest first, with last on the
// final one; with nothing ready it returns a single empty word.
module tick_task_scheduler_table import tts_pkg::*; #(
  parameter int SLOTS      = DEF_SLOTS,
  parameter int TICK_WIDTH = DEF_TICK_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tts_req_if.sink    req_i,
  tts_rsp_if.source  rsp_o
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  tts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  tts_back #(
    .SLOTS      (SLOTS),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .rsp_o       (rsp_o)
  );

  a_due_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.task_due |->
      rsp_o.status == STATUS_OK && int'(rsp_o.slot_index) < SLOTS)
    else $error("dispatched word with bad status or slot");

  a_err_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != STATUS_OK |->
      rsp_o.sticky_error && rsp_o.last && !rsp_o.task_due)
    else $error("error word without sticky flag");

  a_full_none : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == STATUS_FULL |-> rsp_o.slot_index == NONE_SLOT)
    else $error("table full word names a slot");

endmodule

[tb/tb_tick_task_scheduler_table.sv]
`timescale 1ns / 100ps

module tb_tick_task_scheduler_table;
  import tts_pkg::*;

  localparam int NUM_SLOTS = DEF_SLOTS;
  localparam int SPAN_W    = DEF_TICK_WIDTH;

  localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 2 * NUM_SLOTS + 8;

  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  ident;
    logic [15:0] delay;
    logic [15:0] period;
    logic [3:0]  slot;
  } sched_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tts_req_if req_bus ();
  tts_rsp_if rsp_bus ();

  tick_task_scheduler_table dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the slot table
  logic              slot_live [NUM_SLOTS];
  logic [7:0]        slot_id   [NUM_SLOTS];
  logic [SPAN_W-1:0] slot_wait [NUM_SLOTS];
  logic [SPAN_W-1:0] slot_every[NUM_SLOTS];
  logic [7:0]        slot_runs [NUM_SLOTS];
  logic              err_seen;

  sched_req_t pending_reqs[$];
  rsp_t       due_words[$];
  sched_req_t on_air;

  int queued      = 0;
  int words_seen  = 0;
  int mismatches  = 0;
  int burst_left  = 0;
  int gap_left    = 0;
  int hold_left   = 0;
  int hold_mark   = 60;
  int mode        = 0;
  int mode_left   = 0;

  function automatic rsp_t make_word(logic [1:0] st, logic [4:0] slot, logic [7:0] ident,
                                     logic due, logic fin);
    make_word = '{status: st, slot_index: slot, due_ident: ident, task_due: due,
                  sticky_error: err_seen, last: fin};
  endfunction

  function automatic void wipe_slot(int s);
    slot_live[s]  = 1'b0;
    slot_id[s]    = '0;
    slot_wait[s]  = '0;
    slot_every[s] = '0;
    slot_runs[s]  = '0;
  endfunction

  function automatic void apply_request(sched_req_t rq);
    int         s;
    int         hit;
    logic [1:0] st;
    logic       have_prev;
    rsp_t       prev;
    hit = -1;
    have_prev = 1'b0;
    st = STATUS_OK;
    case (rq.kind)
      REQ_TICK: begin
        for (s = 0; s < NUM_SLOTS; s++) begin
          if (slot_live[s]) begin
            if (slot_wait[s] == '0) begin
              if (slot_runs[s] != PEND_MAX) slot_runs[s]++;
              if (slot_every[s] != '0) slot_wait[s] = slot_every[s];
            end else begin
              slot_wait[s] = slot_wait[s] - SPAN_W'(1);
            end
          end
        end
        due_words.push_back(make_word(STATUS_OK, NONE_SLOT, 8'd0, 1'b0, 1'b1));
      end
      REQ_ADD: begin
        for (s = 0; s < NUM_SLOTS; s++)
          if (!slot_live[s] && hit < 0) hit = s;
        if (hit < 0) begin
          err_seen = 1'b1;
          due_words.push_back(make_word(STATUS_FULL, NONE_SLOT, 8'd0, 1'b0, 1'b1));
        end else begin
          slot_live[hit]  = 1'b1;
          slot_id[hit]    = rq.ident;
          slot_wait[hit]  = rq.delay[SPAN_W-1:0];
          slot_every[hit] = rq.period[SPAN_W-1:0];
          slot_runs[hit]  = '0;
          due_words.push_back(make_word(STATUS_OK, 5'(hit), 8'd0, 1'b0, 1'b1));
        end
      end
      REQ_DELETE: begin
        if (!slot_live[rq.slot]) begin
          err_seen = 1'b1;
          st = STATUS_EMPTY;
        end
        wipe_slot(int'(rq.slot));
        due_words.push_back(make_word(st, NONE_SLOT, 8'd0, 1'b0, 1'b1));
      end
      REQ_DISPATCH: begin
        for (s = 0; s < NUM_SLOTS; s++) begin
          if (slot_runs[s] != '0) begin
            if (have_prev) due_words.push_back(prev);
            prev = make_word(STATUS_OK, 5'(s), slot_id[s], 1'b1, 1'b0);
            have_prev = 1'b1;
            slot_runs[s]--;
            if (slot_every[s] == '0) wipe_slot(s);
          end
        end
        if (have_prev) begin
          prev.last = 1'b1;
          due_words.push_back(prev);
        end else begin
          due_words.push_back(make_word(STATUS_OK, NONE_SLOT, 8'd0, 1'b0, 1'b1));
        end
      end
      REQ_CLEAR: begin
        for (s = 0; s < NUM_SLOTS; s++) wipe_slot(s);
        err_seen = 1'b0;
        due_words.push_back(make_word(STATUS_OK, NONE_SLOT, 8'd0, 1'b0, 1'b1));
      end
      default: begin
        due_words.push_back(make_word(STATUS_OK, NONE_SLOT, 8'd0, 1'b0, 1'b1));
      end
    endcase
  endfunction

  task automatic queue_request(logic [2:0] kind, logic [7:0] ident, logic [15:0] delay,
                               logic [15:0] period, logic [3:0] slot);
    sched_req_t rq;
    rq = '{kind: kind, ident: ident, delay: delay, period: period, slot: slot};
    pending_reqs.push_back(rq);
    queued++;
  endtask

  function automatic logic [15:0] pick_span();
    case ($urandom_range(0, 7))
      0:       pick_span = 16'd0;
      1, 2, 3, 4: pick_span = 16'($urandom_range(1, 4));
      5:       pick_span = 16'($urandom_range(5, 40));
      6:       pick_span = 16'($urandom);
      default: pick_span = 16'hFFFF;
    endcase
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_bus.valid || due_words.size() != 0)
      @(posedge clk);
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_bus.valid         <= 1'b0;
      req_bus.req_type      <= '0;
      req_bus.task_ident    <= '0;
      req_bus.first_delay   <= '0;
      req_bus.repeat_period <= '0;
      req_bus.target_slot   <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (req_bus.valid && req_bus.ready) apply_request(on_air);
      if (!req_bus.valid || req_bus.ready) begin
        if (gap_left != 0 || pending_reqs.size() == 0) begin
          if (gap_left != 0) gap_left--;
          req_bus.valid <= 1'b0;
        end else begin
          on_air = pending_reqs.pop_front();
          req_bus.req_type      <= on_air.kind;
          req_bus.task_ident    <= on_air.ident;
          req_bus.first_delay   <= on_air.delay;
          req_bus.repeat_period <= on_air.period;
          req_bus.target_slot   <= on_air.slot;
          req_bus.valid         <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // receiver: stall pattern plus occasional long hold
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
      hold_left = 0;
      mode = 0;
      mode_left = 0;
    end else if (hold_left != 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else if (words_seen >= hold_mark && pending_reqs.size() > 8) begin
      hold_left = HOLD_CYCLES;
      hold_mark = words_seen + 500;
      rsp_bus.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (mode)
        0:       rsp_bus.ready <= 1'b1;
        1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
        default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : watch
    rsp_t seen;
    rsp_t want;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      words_seen++;
      seen = '{status: rsp_bus.status, slot_index: rsp_bus.slot_index,
               due_ident: rsp_bus.due_ident, task_due: rsp_bus.task_due,
               sticky_error: rsp_bus.sticky_error, last: rsp_bus.last};
      if (due_words.size() == 0) begin
        $display("%0t ns: unexpected word, expected none, actual %h", $time, seen);
        mismatches++;
      end else begin
        want = due_words.pop_front();
        check_field("status", want.status, seen.status);
        check_field("slot_index", want.slot_index, seen.slot_index);
        check_field("due_ident", want.due_ident, seen.due_ident);
        check_field("task_due", want.task_due, seen.task_due);
        check_field("sticky_error", want.sticky_error, seen.sticky_error);
        check_field("last", want.last, seen.last);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin : stim
    int k;
    int m;
    int r;
    for (k = 0; k < NUM_SLOTS; k++) wipe_slot(k);
    err_seen = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    queue_request(REQ_CLEAR, 8'd0, 16'd0, 16'd0, 4'd0);
    queue_request(REQ_DISPATCH, 8'd0, 16'd0, 16'd0, 4'd0);
    queue_request(REQ_ADD, 8'd0, 16'd0, 16'd0, 4'd0);
    queue_request(REQ_ADD, 8'hFF, 16'hFFFF, 16'hFFFF, 4'hF);
    queue_request(REQ_ADD, 8'h5A, 16'd1, 16'd1, 4'd0);
    queue_request(REQ_ADD, 8'hA5, 16'd0, 16'hFFFF, 4'd0);
    queue_request(REQ_TICK, 8'd0, 16'd0, 16'd0, 4'd0);
    queue_request(REQ_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 4'hF);
    queue_request(REQ_DISPATCH, 8'd0, 16'd0, 16'd0, 4'd0);
    queue_request(REQ_DELETE, 8'd0, 16'd0, 16'd0, 4'd1);
    queue_request(REQ_DELETE, 8'd0, 16'd0, 16'd0, 4'hF);
    queue_request(REQ_DELETE, 8'd0, 16'd0, 16'd0, 4'd1);
    queue_request(REQ_ADD, 8'h3C, 16'd2, 16'd0, 4'd0);
    for (k = REQ_SPARE_FIRST; k <= REQ_SPARE_LAST; k++)
      queue_request(3'(k), 8'hFF, 16'hFFFF, 16'hFFFF, 4'hF);
    queue_request(REQ_TICK, 8'd0, 16'd0, 16'd0, 4'd0);
    queue_request(REQ_DISPATCH, 8'd0, 16'd0, 16'd0, 4'd0);
    queue_request(REQ_CLEAR, 8'hFF, 16'hFFFF, 16'hFFFF, 4'hF);
    queue_request(REQ_DISPATCH, 8'hFF, 16'hFFFF, 16'hFFFF, 4'hF);
    queue_request(REQ_DELETE, 8'd0, 16'd0, 16'd0, 4'hA);
    queue_request(REQ_CLEAR, 8'd0, 16'd0, 16'd0, 4'd0);
    wait_drained();

    // random part, with one pause for saturation of the run count
    for (k = 0; k < 2; k++) begin
      while (queued < (k == 0 ? 150 : 420)) begin
        r = $urandom_range(0, 9);
        if (r < 2) begin
          queue_request(REQ_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom),
                        4'($urandom));
          repeat ($urandom_range(16, 18))
            queue_request(REQ_ADD, 8'($urandom), 16'($urandom_range(0, 3)), pick_span(),
                          4'($urandom));
          repeat (3)
            queue_request(REQ_TICK, 8'($urandom), 16'($urandom), 16'($urandom),
                          4'($urandom));
          repeat (2)
            queue_request(REQ_DISPATCH, 8'($urandom), 16'($urandom), 16'($urandom),
                          4'($urandom));
        end else if (r == 2) begin
          repeat (5)
            queue_request(3'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                          4'($urandom));
        end else begin
          repeat ($urandom_range(1, 4))
            queue_request(REQ_ADD, 8'($urandom), pick_span(), pick_span(), 4'($urandom));
          m = $urandom_range(6, 16);
          repeat (m) begin
            r = $urandom_range(0, 9);
            if (r < 5)
              queue_request(REQ_TICK, 8'($urandom), 16'($urandom), 16'($urandom),
                            4'($urandom));
            else if (r < 8)
              queue_request(REQ_DISPATCH, 8'($urandom), 16'($urandom), 16'($urandom),
                            4'($urandom));
            else if (r == 8)
              queue_request(REQ_DELETE, 8'($urandom), 16'($urandom), 16'($urandom),
                            4'($urandom_range(0, 15)));
            else
              queue_request(REQ_ADD, 8'($urandom), pick_span(), pick_span(),
                            4'($urandom));
          end
        end
      end
      if (k == 0) begin
        wait_drained();
        queue_request(REQ_CLEAR, 8'd0, 16'd0, 16'd0, 4'd0);
        queue_request(REQ_ADD, 8'($urandom), 16'd0, 16'd0, 4'd0);
        queue_request(REQ_ADD, 8'($urandom), 16'd0, 16'd1, 4'd0);
        repeat (258)
          queue_request(REQ_TICK, 8'($urandom), 16'($urandom), 16'($urandom),
                        4'($urandom));
        repeat (2)
          queue_request(REQ_DISPATCH, 8'($urandom), 16'($urandom), 16'($urandom),
                        4'($urandom));
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
